@@ rtl/core/ceke_pkg.sv @@
// ----------------------------------------------------------------------------
// ceke_pkg
// Shared widths, coefficient tables and helpers for the elliptic K/E pipeline.
// ----------------------------------------------------------------------------
package ceke_pkg;

  // inner fixed point: Q16.48
  localparam int FRAC       = 48;
  localparam int XW         = 48;   // width of 1 - m before scaling
  localparam int MANT_W     = 49;   // Q1.48 mantissa
  localparam int SQ_W       = 50;   // Q2.48 square
  localparam int ACC_W      = 50;   // polynomial accumulator
  localparam int LG_W       = 55;   // -ln m0 and its integer-plus-fraction form
  localparam int LOG_ITERS  = 44;
  localparam int LEAD_W     = 6;
  localparam int ILOG_W     = 7;
  localparam int SUM_W      = 56;
  localparam int RES_W      = 32;

  localparam int IN_FRAC_BITS_DEF  = 32;
  localparam int OUT_FRAC_BITS_DEF = 28;

  localparam logic [63:0] DEC_ONE = 64'd100000000000;
  localparam logic [63:0] LN2_DEC = 64'd69314718056;

  // polynomial selectors
  localparam int POLY_K_A = 0;
  localparam int POLY_K_B = 1;
  localparam int POLY_E_A = 2;
  localparam int POLY_E_B = 3;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [63:0] K_PA_DEC [5] = '{64'd138629436112, 64'd9666344259,
                                           64'd3590092383, 64'd3742563713, 64'd1451196212};
  localparam logic [63:0] K_PB_DEC [5] = '{64'd50000000000, 64'd12498593597,
                                           64'd6880248576, 64'd3328355346, 64'd441787012};
  localparam logic [63:0] E_PA_DEC [5] = '{64'd100000000000, 64'd44325141463,
                                           64'd6260601220, 64'd4757383546, 64'd1736506451};
  localparam logic [63:0] E_PB_DEC [5] = '{64'd0, 64'd24998368310,
                                           64'd9200180037, 64'd4069697526, 64'd526449639};

  // decimal n / 10^11 to Q.48, round half up (elaboration only)
  function automatic logic [63:0] dec_to_fix(input logic [63:0] n);
    logic [63:0] q;
    logic [63:0] r;
    q = n / DEC_ONE;
    r = n % DEC_ONE;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC_ONE) begin
        q = q | 64'd1;
        r = r - DEC_ONE;
      end
    end
    r = r << 1;
    if (r >= DEC_ONE) q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [ACC_W-1:0] coef_fix(input int poly, input int idx);
    logic [63:0] d;
    case (poly)
      POLY_K_A: d = K_PA_DEC[idx];
      POLY_K_B: d = K_PB_DEC[idx];
      POLY_E_A: d = E_PA_DEC[idx];
      POLY_E_B: d = E_PB_DEC[idx];
      default:  d = 64'd0;
    endcase
    return ACC_W'(dec_to_fix(d));
  endfunction

  localparam logic [ACC_W-1:0] LN2_FIX = ACC_W'(dec_to_fix(LN2_DEC));

endpackage

@@ rtl/core/ceke_delay.sv @@
// ----------------------------------------------------------------------------
// ceke_delay
// Stall-aware shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module ceke_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < N; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[N-1];
endmodule

@@ rtl/core/ceke_fxm.sv @@
// ----------------------------------------------------------------------------
// ceke_fxm
// Two-stage Q.48 multiplier: 32-bit partial products, then sum and round.
// ----------------------------------------------------------------------------
module ceke_fxm #(
  parameter int AW = 49,
  parameter int BW = 49,
  parameter int OW = 50
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [OW-1:0] p
);
  import ceke_pkg::*;

  localparam int AH = AW - 32;
  localparam int BH = BW - 32;
  localparam int PW = AW + BW + 1;

  logic [63:0]      pll;
  logic [BW-1:0]    plh;
  logic [AW-1:0]    phl;
  logic [AH+BH-1:0] phh;
  logic [PW-1:0]    sum;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= a[31:0] * b[31:0];
      plh <= a[31:0] * b[BW-1:32];
      phl <= a[AW-1:32] * b[31:0];
      phh <= a[AW-1:32] * b[BW-1:32];
    end
  end

  assign sum = PW'(pll) + (PW'(plh) << 32) + (PW'(phl) << 32) + (PW'(phh) << 64)
             + (PW'(1) << (FRAC - 1));

  always_ff @(posedge clk) begin
    if (en) p <= sum[FRAC +: OW];
  end
endmodule

@@ rtl/core/ceke_log_step.sv @@
// ----------------------------------------------------------------------------
// ceke_log_step
// One squaring step of the mantissa log2: square, then emit one bit.
// ----------------------------------------------------------------------------
module ceke_log_step (
  input  logic                               clk,
  input  logic                               en,
  input  logic [ceke_pkg::MANT_W-1:0]        y_in,
  input  logic [ceke_pkg::LOG_ITERS-1:0]     bits_in,
  output logic [ceke_pkg::MANT_W-1:0]        y_out,
  output logic [ceke_pkg::LOG_ITERS-1:0]     bits_out
);
  import ceke_pkg::*;

  logic [SQ_W-1:0]      sq;
  logic [LOG_ITERS-1:0] bits_a;
  logic [LOG_ITERS-1:0] bits_b;

  ceke_fxm #(.AW(MANT_W), .BW(MANT_W), .OW(SQ_W)) u_sq (
    .clk(clk), .en(en), .a(y_in), .b(y_in), .p(sq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      bits_a <= bits_in;
      bits_b <= bits_a;
    end
  end

  // square at or above 2: emit a one and halve
  assign y_out    = sq[SQ_W-1] ? sq[SQ_W-1:1] : sq[MANT_W-1:0];
  assign bits_out = {bits_b[LOG_ITERS-2:0], sq[SQ_W-1]};
endmodule

@@ rtl/core/ceke_horner.sv @@
// ----------------------------------------------------------------------------
// ceke_horner
// Degree-4 Horner evaluation in m0, three register stages per coefficient.
// ----------------------------------------------------------------------------
module ceke_horner #(
  parameter int POLY = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ceke_pkg::XW-1:0]       z_in,
  output logic [ceke_pkg::ACC_W-1:0]    acc_out
);
  import ceke_pkg::*;

  logic [ACC_W-1:0] acc_ch [5];
  logic [XW-1:0]    z_ch   [4];

  assign acc_ch[0] = coef_fix(POLY, 4);
  assign z_ch[0]   = z_in;

  for (genvar j = 0; j < 4; j++) begin : g_step
    localparam logic [ACC_W-1:0] CJ = coef_fix(POLY, 3 - j);
    logic [ACC_W-1:0] prod;

    ceke_fxm #(.AW(ACC_W), .BW(XW), .OW(ACC_W)) u_mul (
      .clk(clk), .en(en), .a(acc_ch[j]), .b(z_ch[j]), .p(prod)
    );

    always_ff @(posedge clk) begin
      if (en) acc_ch[j+1] <= prod + CJ;
    end

    if (j < 3) begin : g_z
      ceke_delay #(.W(XW), .N(3)) u_zd (
        .clk(clk), .en(en), .d(z_ch[j]), .q(z_ch[j+1])
      );
    end
  end

  assign acc_out = acc_ch[4];
endmodule

@@ rtl/core/complete_elliptic_k_e_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// complete_elliptic_k_e_evaluator_top
// K(m) and E(m) by polynomial-plus-logarithm approximation, fully pipelined.
// ----------------------------------------------------------------------------
// One m per clock enters and one K/E pair leaves per clock while the pipeline
// is not frozen. The longest path is the mantissa logarithm: 44 squaring steps
// of two stages each, followed by the ln2 scaling and the final product stages.
// When out_stall holds a valid result, the whole pipeline freezes and in_stall
// rises in the same cycle. m = 0 returns zero results with status_code 1.
module complete_elliptic_k_e_evaluator_top #(
  parameter int IN_FRAC_BITS  = ceke_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = ceke_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] m_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] k_result,
  output logic [31:0] e_result,
  output logic        status_code
);
  import ceke_pkg::*;

  localparam int LAT      = 97;
  localparam int LOG_LAT  = 2 * LOG_ITERS;
  localparam int ZSH      = FRAC - IN_FRAC_BITS;
  localparam int OSH      = FRAC - OUT_FRAC_BITS;
  localparam logic [XW-1:0] ONE_X = XW'(1) << IN_FRAC_BITS;
  localparam logic [XW-1:0] MASK  = ONE_X - XW'(1);
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (OSH - 1);

  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // front: 1 - m, leading one, normalize
  logic [XW-1:0]     m_ext;
  logic [XW-1:0]     x1, x2, x3;
  logic              zero1, zero2, zero3;
  logic [LEAD_W-1:0] lead_c, lead2;
  logic [MANT_W-1:0] y3;
  logic [ILOG_W-1:0] ilog3;

  assign m_ext = XW'(m_value) & MASK;

  always_comb begin
    lead_c = '0;
    for (int i = 0; i < XW; i++) begin
      if (x1[i]) lead_c = LEAD_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= ONE_X - m_ext;
      zero1 <= (m_ext == '0);
      x2    <= x1;
      zero2 <= zero1;
      lead2 <= lead_c;
      x3    <= x2;
      zero3 <= zero2;
      y3    <= MANT_W'(x2) << (LEAD_W'(FRAC) - lead2);
      ilog3 <= ILOG_W'(IN_FRAC_BITS) - ILOG_W'(lead2);
    end
  end

  // mantissa log2 chain
  logic [MANT_W-1:0]    y_ch [LOG_ITERS];
  logic [LOG_ITERS-1:0] b_ch [LOG_ITERS+1];

  assign y_ch[0] = y3;
  assign b_ch[0] = '0;

  for (genvar j = 0; j < LOG_ITERS; j++) begin : g_log
    if (j < LOG_ITERS - 1) begin : g_mid
      ceke_log_step u_step (
        .clk(clk), .en(en), .y_in(y_ch[j]), .bits_in(b_ch[j]),
        .y_out(y_ch[j+1]), .bits_out(b_ch[j+1])
      );
    end else begin : g_last
      ceke_log_step u_step (
        .clk(clk), .en(en), .y_in(y_ch[j]), .bits_in(b_ch[j]),
        .y_out(), .bits_out(b_ch[j+1])
      );
    end
  end

  // polynomials in m0, started alongside the log chain
  logic [XW-1:0]    z3;
  logic [ACC_W-1:0] kpa, kpb, epa, epb;

  assign z3 = x3 << ZSH;

  ceke_horner #(.POLY(POLY_K_A)) u_kpa (.clk(clk), .en(en), .z_in(z3), .acc_out(kpa));
  ceke_horner #(.POLY(POLY_K_B)) u_kpb (.clk(clk), .en(en), .z_in(z3), .acc_out(kpb));
  ceke_horner #(.POLY(POLY_E_A)) u_epa (.clk(clk), .en(en), .z_in(z3), .acc_out(epa));
  ceke_horner #(.POLY(POLY_E_B)) u_epb (.clk(clk), .en(en), .z_in(z3), .acc_out(epb));

  // side data aligned to the log result
  logic [ILOG_W-1:0] ilog_d;
  logic              zero_d;
  logic [ACC_W-1:0]  kpb_d, epb_d, kpa_d, epa_d;

  ceke_delay #(.W(ILOG_W), .N(LOG_LAT)) u_ilog_d (
    .clk(clk), .en(en), .d(ilog3), .q(ilog_d)
  );
  ceke_delay #(.W(1), .N(LAT - 4)) u_zero_d (
    .clk(clk), .en(en), .d(zero3), .q(zero_d)
  );
  ceke_delay #(.W(ACC_W), .N(79)) u_kpb_d (.clk(clk), .en(en), .d(kpb), .q(kpb_d));
  ceke_delay #(.W(ACC_W), .N(79)) u_epb_d (.clk(clk), .en(en), .d(epb), .q(epb_d));
  ceke_delay #(.W(ACC_W), .N(81)) u_kpa_d (.clk(clk), .en(en), .d(kpa), .q(kpa_d));
  ceke_delay #(.W(ACC_W), .N(81)) u_epa_d (.clk(clk), .en(en), .d(epa), .q(epa_d));

  // -ln m0 = (integer part - fraction) * ln2
  logic [LG_W-1:0] whole;
  logic [LG_W-1:0] lg;
  logic [LG_W-1:0] kprod, eprod;

  always_ff @(posedge clk) begin
    if (en) begin
      whole <= (LG_W'(ilog_d) << FRAC)
             - (LG_W'(b_ch[LOG_ITERS]) << (FRAC - LOG_ITERS));
    end
  end

  ceke_fxm #(.AW(LG_W), .BW(ACC_W), .OW(LG_W)) u_ln2 (
    .clk(clk), .en(en), .a(whole), .b(LN2_FIX), .p(lg)
  );
  ceke_fxm #(.AW(ACC_W), .BW(LG_W), .OW(LG_W)) u_kmul (
    .clk(clk), .en(en), .a(kpb_d), .b(lg), .p(kprod)
  );
  ceke_fxm #(.AW(ACC_W), .BW(LG_W), .OW(LG_W)) u_emul (
    .clk(clk), .en(en), .a(epb_d), .b(lg), .p(eprod)
  );

  // output rounding and saturation
  logic [SUM_W-1:0] ksum, esum, kshr, eshr;

  assign ksum = SUM_W'(kpa_d) + SUM_W'(kprod) + RND;
  assign esum = SUM_W'(epa_d) + SUM_W'(eprod) + RND;
  assign kshr = ksum >> OSH;
  assign eshr = esum >> OSH;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_d) begin
        k_result    <= '0;
        e_result    <= '0;
        status_code <= STATUS_RANGE;
      end else begin
        k_result    <= (kshr[SUM_W-1:RES_W] != '0) ? '1 : kshr[RES_W-1:0];
        e_result    <= (eshr[SUM_W-1:RES_W] != '0) ? '1 : eshr[RES_W-1:0];
        status_code <= STATUS_OK;
      end
    end
  end
endmodule

@@ rtl/core/ceke_check.sv @@
// ----------------------------------------------------------------------------
// ceke_check
// Port-level checks on the evaluator's handshake and result coding.
// ----------------------------------------------------------------------------
module ceke_check (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] k_result,
  input logic [31:0] e_result,
  input logic        status_code
);
  import ceke_pkg::*;

  // a held transaction stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(k_result) && $stable(e_result))
    else $error("result changed while stalled");

  // back pressure reaches the input in the same cycle
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // out-of-range parameter gives zero results
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_code == STATUS_RANGE |-> k_result == '0 && e_result == '0)
    else $error("nonzero result with range status");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind complete_elliptic_k_e_evaluator_top ceke_check u_ceke_check (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .k_result(k_result),
  .e_result(e_result), .status_code(status_code)
);
